### rtl/rotated_shape_point_coverage_top_macros.svh
// ----------------------------------------------------------------------------
// Rotated shape point coverage assertion macros
// Clocked assertion shorthands on clock with reset as disable.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SHAPE_POINT_COVERAGE_TOP_MACROS_SVH
`define ROTATED_SHAPE_POINT_COVERAGE_TOP_MACROS_SVH
`ifndef SYNTH
`define RSPC_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
`define RSPC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define RSPC_ASSERT_SAME(label, pre, post)
`define RSPC_ASSERT_NEXT(label, pre, post)
`endif
`endif

### rtl/rspc_pkg.sv
// ----------------------------------------------------------------------------
// Rotated shape point coverage package
// Register indexes, shape codes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rspc_pkg;

   localparam int CSR_DATA_W  = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int TRIG_W      = 16;
   localparam int EXTENT_A_W  = 40;
   localparam int EXTENT_B_W  = 16;
   localparam int CHAR_W      = 8;
   localparam int SHAPE_W     = 2;
   localparam int TRIG_FRAC   = 14;
   localparam int ROUND_HALF  = 8192;
   localparam int CIRCLE_W    = 20;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [SHAPE_W-1:0]     shape_type;

   localparam csr_index_type REG_SHAPE_TYPE  = 3'd0;
   localparam csr_index_type REG_CENTRE_X    = 3'd1;
   localparam csr_index_type REG_CENTRE_Y    = 3'd2;
   localparam csr_index_type REG_COS_ANGLE   = 3'd3;
   localparam csr_index_type REG_SIN_ANGLE   = 3'd4;
   localparam csr_index_type REG_EXTENT_A    = 3'd5;
   localparam csr_index_type REG_EXTENT_B    = 3'd6;
   localparam csr_index_type REG_COLOUR_CHAR = 3'd7;

   localparam shape_type SHAPE_CIRCLE = 2'd0;
   localparam shape_type SHAPE_RECT   = 2'd1;
   localparam shape_type SHAPE_LINE   = 2'd2;
   localparam shape_type SHAPE_NONE   = 2'd3;

   localparam logic [TRIG_W-1:0] COS_RESET    = 16'd16384;
   localparam logic [CHAR_W-1:0] COLOUR_RESET = 8'd43;

endpackage

### rtl/rotated_shape_point_coverage_top.sv
// ----------------------------------------------------------------------------
// Rotated shape point coverage
// Translates a point into figure space, rotates it by the figure angle and
// tests it against a circle, rectangle or line.
// ----------------------------------------------------------------------------
// Accepts one point per cycle while req_stall is low and returns one result
// per point through a five-stage pipeline: centre subtract, four rotation
// products, rounding and magnitude, squares and box compares, final select.
// When the output register holds a transaction that is stalled, the whole
// pipeline holds and req_stall is raised in the same cycle. The user (not the
// block) must write registers via csr only while no transaction is in flight.
`timescale 1ns / 1ps
`include "rotated_shape_point_coverage_top_macros.svh"

module rotated_shape_point_coverage_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_WIDTH-1:0]      req_point_x,
   input  logic signed [COORD_WIDTH-1:0]      req_point_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [rspc_pkg::CHAR_W-1:0]        rsp_cover_char,
   input  logic                               csr_wr_en,
   input  rspc_pkg::csr_index_type            csr_index,
   input  logic [rspc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = DW + rspc_pkg::TRIG_W;
   localparam int SW  = PW + 1;
   localparam int AW  = SW - rspc_pkg::TRIG_FRAC;
   localparam int CXW = (AW > rspc_pkg::CIRCLE_W) ? AW : rspc_pkg::CIRCLE_W;
   localparam int BXW = (AW > rspc_pkg::EXTENT_B_W) ? AW : rspc_pkg::EXTENT_B_W;
   localparam int QW  = 2 * rspc_pkg::CIRCLE_W;

   // configuration registers
   rspc_pkg::shape_type                 shape_type_ff;
   logic [COORD_WIDTH-1:0]              centre_x_ff;
   logic [COORD_WIDTH-1:0]              centre_y_ff;
   logic signed [rspc_pkg::TRIG_W-1:0]  cos_angle_ff;
   logic signed [rspc_pkg::TRIG_W-1:0]  sin_angle_ff;
   logic [rspc_pkg::EXTENT_A_W-1:0]     extent_a_ff;
   logic [rspc_pkg::EXTENT_B_W-1:0]     extent_b_ff;
   logic [rspc_pkg::CHAR_W-1:0]         colour_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_type_ff  <= rspc_pkg::SHAPE_CIRCLE;
         centre_x_ff    <= '0;
         centre_y_ff    <= '0;
         cos_angle_ff   <= rspc_pkg::COS_RESET;
         sin_angle_ff   <= '0;
         extent_a_ff    <= '0;
         extent_b_ff    <= '0;
         colour_char_ff <= rspc_pkg::COLOUR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rspc_pkg::REG_SHAPE_TYPE:  shape_type_ff  <= csr_data[rspc_pkg::SHAPE_W-1:0];
            rspc_pkg::REG_CENTRE_X:    centre_x_ff    <= csr_data[COORD_WIDTH-1:0];
            rspc_pkg::REG_CENTRE_Y:    centre_y_ff    <= csr_data[COORD_WIDTH-1:0];
            rspc_pkg::REG_COS_ANGLE:   cos_angle_ff   <= csr_data[rspc_pkg::TRIG_W-1:0];
            rspc_pkg::REG_SIN_ANGLE:   sin_angle_ff   <= csr_data[rspc_pkg::TRIG_W-1:0];
            rspc_pkg::REG_EXTENT_A:    extent_a_ff    <= csr_data[rspc_pkg::EXTENT_A_W-1:0];
            rspc_pkg::REG_EXTENT_B:    extent_b_ff    <= csr_data[rspc_pkg::EXTENT_B_W-1:0];
            rspc_pkg::REG_COLOUR_CHAR: colour_char_ff <= csr_data[rspc_pkg::CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control: hold everything while the output is stalled
   logic [4:0] vld_ff;
   logic [4:0] vld_in;
   logic       advance;

   assign advance   = !(vld_ff[4] && rsp_stall);
   assign req_stall = !advance;
   assign vld_in    = {vld_ff[3:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: subtract centre
   logic signed [DW-1:0] dx_ff, dx_in;
   logic signed [DW-1:0] dy_ff, dy_in;

   assign dx_in = {req_point_x[COORD_WIDTH-1], req_point_x}
                - {centre_x_ff[COORD_WIDTH-1], centre_x_ff};
   assign dy_in = {req_point_y[COORD_WIDTH-1], req_point_y}
                - {centre_y_ff[COORD_WIDTH-1], centre_y_ff};

   // stage 2: rotation products
   logic signed [PW-1:0] pxc_ff, pxc_in;
   logic signed [PW-1:0] pys_ff, pys_in;
   logic signed [PW-1:0] pyc_ff, pyc_in;
   logic signed [PW-1:0] pxs_ff, pxs_in;

   assign pxc_in = PW'(dx_ff) * PW'(cos_angle_ff);
   assign pys_in = PW'(dy_ff) * PW'(sin_angle_ff);
   assign pyc_in = PW'(dy_ff) * PW'(cos_angle_ff);
   assign pxs_in = PW'(dx_ff) * PW'(sin_angle_ff);

   // stage 3: sum, round to nearest with ties up, take magnitude
   logic [SW-1:0] sum_x;
   logic [SW-1:0] sum_y;
   logic [AW-1:0] rx;
   logic [AW-1:0] ry;
   logic [AW-1:0] ax_ff, ax_in;
   logic [AW-1:0] ay_ff, ay_in;

   assign sum_x = SW'(pxc_ff) + SW'(pys_ff) + SW'(rspc_pkg::ROUND_HALF);
   assign sum_y = SW'(pyc_ff) - SW'(pxs_ff) + SW'(rspc_pkg::ROUND_HALF);
   assign rx    = sum_x[SW-1:rspc_pkg::TRIG_FRAC];
   assign ry    = sum_y[SW-1:rspc_pkg::TRIG_FRAC];
   assign ax_in = rx[AW-1] ? AW'(-rx) : rx;
   assign ay_in = ry[AW-1] ? AW'(-ry) : ry;

   // stage 4: squares and box compares
   logic [CXW-1:0] ax_cx;
   logic [CXW-1:0] ay_cx;
   logic [BXW-1:0] ay_bx;
   logic [BXW-1:0] eb_bx;
   logic [QW-1:0]  sqx_ff, sqx_in;
   logic [QW-1:0]  sqy_ff, sqy_in;
   logic           near_ff, near_in;
   logic           box_ff, box_in;

   assign ax_cx   = CXW'(ax_ff);
   assign ay_cx   = CXW'(ay_ff);
   assign ay_bx   = BXW'(ay_ff);
   assign eb_bx   = BXW'(extent_b_ff);
   assign sqx_in  = QW'(ax_cx[rspc_pkg::CIRCLE_W-1:0]) * QW'(ax_cx[rspc_pkg::CIRCLE_W-1:0]);
   assign sqy_in  = QW'(ay_cx[rspc_pkg::CIRCLE_W-1:0]) * QW'(ay_cx[rspc_pkg::CIRCLE_W-1:0]);
   assign near_in = ((ax_cx >> rspc_pkg::CIRCLE_W) == '0)
                 && ((ay_cx >> rspc_pkg::CIRCLE_W) == '0);
   assign box_in  = (rspc_pkg::EXTENT_A_W'(ax_ff) <= extent_a_ff) && (ay_bx <= eb_bx);

   // stage 5: select by shape
   logic [QW:0]                 rad_sq;
   logic                        hit_ff, hit_in;
   logic [rspc_pkg::CHAR_W-1:0] char_ff, char_in;

   assign rad_sq = (QW + 1)'(sqx_ff) + (QW + 1)'(sqy_ff);

   always_comb begin
      unique case (shape_type_ff)
         rspc_pkg::SHAPE_CIRCLE: hit_in = near_ff && (rad_sq <= (QW + 1)'(extent_a_ff));
         rspc_pkg::SHAPE_RECT:   hit_in = box_ff;
         rspc_pkg::SHAPE_LINE:   hit_in = box_ff;
         default:                hit_in = 1'b0;
      endcase
      char_in = hit_in ? colour_char_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         pxc_ff  <= pxc_in;
         pys_ff  <= pys_in;
         pyc_ff  <= pyc_in;
         pxs_ff  <= pxs_in;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         near_ff <= near_in;
         box_ff  <= box_in;
         hit_ff  <= hit_in;
         char_ff <= char_in;
      end
   end

   assign rsp_valid      = vld_ff[4];
   assign rsp_hit        = hit_ff;
   assign rsp_cover_char = char_ff;

   `RSPC_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, vld_ff[0])
   `RSPC_ASSERT_NEXT(a_stall_holds_pipe, rsp_valid && rsp_stall, $stable(vld_ff))
   `RSPC_ASSERT_SAME(a_stall_only_on_output, req_stall, rsp_valid && rsp_stall)
   `RSPC_ASSERT_NEXT(a_none_never_hits, vld_ff[3] && advance && shape_type_ff == rspc_pkg::SHAPE_NONE, rsp_valid && !rsp_hit)

endmodule

### tb/sv/rotated_shape_point_coverage_top_tb.sv
// ----------------------------------------------------------------------------
// Rotated shape point coverage testbench
// Feeds directed and random points against circle, rectangle, line and empty
// figures, predicts each translated and rotated coverage result in fixed
// point, and checks every returned transaction in order under random sender
// bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotated_shape_point_coverage_top_tb;

   localparam int COORD_W      = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic                        hit;
      logic [rspc_pkg::CHAR_W-1:0] cover_char;
   } cover_result_type;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_stall;
   logic signed [COORD_W-1:0]       req_point_x    = '0;
   logic signed [COORD_W-1:0]       req_point_y    = '0;
   logic                            rsp_valid;
   logic                            rsp_stall      = 1'b0;
   logic                            rsp_hit;
   logic [rspc_pkg::CHAR_W-1:0]     rsp_cover_char;
   logic                            csr_wr_en      = 1'b0;
   rspc_pkg::csr_index_type         csr_index      = rspc_pkg::REG_SHAPE_TYPE;
   logic [rspc_pkg::CSR_DATA_W-1:0] csr_data       = '0;

   rspc_pkg::shape_type                 fig_shape;
   logic signed [COORD_W-1:0]           fig_centre_x;
   logic signed [COORD_W-1:0]           fig_centre_y;
   logic signed [rspc_pkg::TRIG_W-1:0]  fig_cos;
   logic signed [rspc_pkg::TRIG_W-1:0]  fig_sin;
   logic [rspc_pkg::EXTENT_A_W-1:0]     fig_extent_a;
   logic [rspc_pkg::EXTENT_B_W-1:0]     fig_extent_b;
   logic [rspc_pkg::CHAR_W-1:0]         fig_colour;

   cover_result_type            cover_expect_q[$];
   cover_result_type            cover_want;
   int                          mismatch_count = 0;
   int                          cycle_count    = 0;
   int                          burst_left     = 0;
   int                          point_span     = 64;
   int                          stall_mode     = 0;
   int                          stall_hold     = 0;
   int                          stall_phase    = 0;

   rotated_shape_point_coverage_top #(
      .COORD_WIDTH(COORD_W)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_cover_char(rsp_cover_char),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_hold = $urandom_range(20, 200);
      end else begin
         stall_hold = stall_hold - 1;
      end
      stall_phase = stall_phase + 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= ((stall_phase % 7) < 3);
      endcase
   end

   function automatic cover_result_type predict_cover(logic signed [COORD_W-1:0] px,
                                                      logic signed [COORD_W-1:0] py);
      longint           dx, dy, c, s, rx, ry, ax, ay, ea, eb;
      logic             covered;
      cover_result_type res;
      dx = longint'(px);
      dy = longint'(py);
      dx = dx - longint'(fig_centre_x);
      dy = dy - longint'(fig_centre_y);
      c  = longint'(fig_cos);
      s  = longint'(fig_sin);
      ea = longint'(fig_extent_a);
      eb = longint'(fig_extent_b);
      rx = (dx * c + dy * s + rspc_pkg::ROUND_HALF) >>> rspc_pkg::TRIG_FRAC;
      ry = (dy * c - dx * s + rspc_pkg::ROUND_HALF) >>> rspc_pkg::TRIG_FRAC;
      ax = (rx < 0) ? -rx : rx;
      ay = (ry < 0) ? -ry : ry;
      case (fig_shape)
         rspc_pkg::SHAPE_CIRCLE:
            covered = (ax < (64'sd1 <<< rspc_pkg::CIRCLE_W)) &&
                      (ay < (64'sd1 <<< rspc_pkg::CIRCLE_W)) &&
                      (ax * ax + ay * ay <= ea);
         rspc_pkg::SHAPE_RECT, rspc_pkg::SHAPE_LINE:
            covered = (ax <= ea) && (ay <= eb);
         default:
            covered = 1'b0;
      endcase
      res.hit        = covered;
      res.cover_char = covered ? fig_colour : '0;
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cover_expect_q.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected transaction: hit %0b char %0d", rsp_hit, rsp_cover_char);
         end else begin
            cover_want = cover_expect_q.pop_front();
            if (rsp_hit !== cover_want.hit || rsp_cover_char !== cover_want.cover_char) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("mismatch: hit exp %0b got %0b, char exp %0d got %0d",
                           cover_want.hit, rsp_hit, cover_want.cover_char, rsp_cover_char);
            end
         end
      end
   end

   task automatic reset_figure();
      fig_shape    = rspc_pkg::SHAPE_CIRCLE;
      fig_centre_x = '0;
      fig_centre_y = '0;
      fig_cos      = rspc_pkg::COS_RESET;
      fig_sin      = '0;
      fig_extent_a = '0;
      fig_extent_b = '0;
      fig_colour   = rspc_pkg::COLOUR_RESET;
   endtask

   task automatic write_reg(input rspc_pkg::csr_index_type idx,
                            input logic [rspc_pkg::CSR_DATA_W-1:0] value,
                            input int width);
      logic [rspc_pkg::CSR_DATA_W-1:0] data;
      logic [63:0]                     junk;
      data = value & ((40'd1 << width) - 40'd1);
      junk = {$urandom, $urandom};
      if (width < rspc_pkg::CSR_DATA_W && $urandom_range(0, 3) == 0)
         data = data | rspc_pkg::CSR_DATA_W'(junk << width);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         rspc_pkg::REG_SHAPE_TYPE: fig_shape    = data[rspc_pkg::SHAPE_W-1:0];
         rspc_pkg::REG_CENTRE_X:   fig_centre_x = data[COORD_W-1:0];
         rspc_pkg::REG_CENTRE_Y:   fig_centre_y = data[COORD_W-1:0];
         rspc_pkg::REG_COS_ANGLE:  fig_cos      = data[rspc_pkg::TRIG_W-1:0];
         rspc_pkg::REG_SIN_ANGLE:  fig_sin      = data[rspc_pkg::TRIG_W-1:0];
         rspc_pkg::REG_EXTENT_A:   fig_extent_a = data[rspc_pkg::EXTENT_A_W-1:0];
         rspc_pkg::REG_EXTENT_B:   fig_extent_b = data[rspc_pkg::EXTENT_B_W-1:0];
         default:                  fig_colour   = data[rspc_pkg::CHAR_W-1:0];
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_figure(input rspc_pkg::shape_type shape, input logic [15:0] cx,
                             input logic [15:0] cy, input logic [15:0] c,
                             input logic [15:0] s, input logic [39:0] ea,
                             input logic [15:0] eb, input logic [7:0] colour);
      write_reg(rspc_pkg::REG_SHAPE_TYPE, rspc_pkg::CSR_DATA_W'(shape), rspc_pkg::SHAPE_W);
      write_reg(rspc_pkg::REG_CENTRE_X, rspc_pkg::CSR_DATA_W'(cx), COORD_W);
      write_reg(rspc_pkg::REG_CENTRE_Y, rspc_pkg::CSR_DATA_W'(cy), COORD_W);
      write_reg(rspc_pkg::REG_COS_ANGLE, rspc_pkg::CSR_DATA_W'(c), rspc_pkg::TRIG_W);
      write_reg(rspc_pkg::REG_SIN_ANGLE, rspc_pkg::CSR_DATA_W'(s), rspc_pkg::TRIG_W);
      write_reg(rspc_pkg::REG_EXTENT_A, ea, rspc_pkg::EXTENT_A_W);
      write_reg(rspc_pkg::REG_EXTENT_B, rspc_pkg::CSR_DATA_W'(eb), rspc_pkg::EXTENT_B_W);
      write_reg(rspc_pkg::REG_COLOUR_CHAR, rspc_pkg::CSR_DATA_W'(colour), rspc_pkg::CHAR_W);
   endtask

   task automatic send_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
      cover_expect_q.push_back(predict_cover(x, y));
      if (burst_left > 0)
         burst_left = burst_left - 1;
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (cover_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_point(16'sd0, 16'sd0);
      send_point(16'sd1, 16'sd0);
      send_point(-16'sd32768, 16'sd32767);
      wait_for_results();
   endtask

   task automatic test_extreme_figure();
      // out-of-range trig values, extreme centre and maximum squared radius
      set_figure(rspc_pkg::SHAPE_CIRCLE, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 40'hff_ffff_ffff, 16'h0000, 8'hff);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd0, 16'sd0);
      wait_for_results();
      write_reg(rspc_pkg::REG_SHAPE_TYPE, rspc_pkg::CSR_DATA_W'(rspc_pkg::SHAPE_NONE),
                rspc_pkg::SHAPE_W);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd32767, -16'sd32768);
      wait_for_results();
      write_reg(rspc_pkg::REG_SHAPE_TYPE, rspc_pkg::CSR_DATA_W'(rspc_pkg::SHAPE_RECT),
                rspc_pkg::SHAPE_W);
      write_reg(rspc_pkg::REG_EXTENT_B, 40'hffff, rspc_pkg::EXTENT_B_W);
      send_point(16'sd32767, -16'sd32768);
      wait_for_results();
      set_figure(rspc_pkg::SHAPE_LINE, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                 40'h0, 16'h0000, 8'h00);
      send_point(-16'sd32768, 16'sd32767);
      send_point(-16'sd32767, 16'sd32767);
      wait_for_results();
   endtask

   task automatic test_each_shape();
      set_figure(rspc_pkg::SHAPE_RECT, 16'd160, -16'sd80, 16'd9830, 16'd13107,
                 40'd320, 16'd160, 8'd65);
      send_point(16'sd160, -16'sd80);
      send_point(16'sd352, 16'sd176);
      send_point(16'sd353, 16'sd177);
      wait_for_results();
      write_reg(rspc_pkg::REG_SHAPE_TYPE, rspc_pkg::CSR_DATA_W'(rspc_pkg::SHAPE_LINE),
                rspc_pkg::SHAPE_W);
      write_reg(rspc_pkg::REG_EXTENT_A, 40'd640, rspc_pkg::EXTENT_A_W);
      write_reg(rspc_pkg::REG_EXTENT_B, 40'd8, rspc_pkg::EXTENT_B_W);
      send_point(16'sd544, 16'sd432);
      send_point(16'sd545, 16'sd433);
      send_point(16'sd150, -16'sd72);
      wait_for_results();
      write_reg(rspc_pkg::REG_SHAPE_TYPE, rspc_pkg::CSR_DATA_W'(rspc_pkg::SHAPE_CIRCLE),
                rspc_pkg::SHAPE_W);
      write_reg(rspc_pkg::REG_EXTENT_A, 40'd102400, rspc_pkg::EXTENT_A_W);
      send_point(16'sd352, 16'sd176);
      send_point(16'sd353, 16'sd177);
      send_point(-16'sd160, 16'sd80);
      wait_for_results();
   endtask

   task automatic random_figure();
      rspc_pkg::shape_type shape;
      logic [15:0]         cx, cy, c, s, eb;
      logic [39:0]         ea;
      int                  sel, ra, rb;
      sel = $urandom_range(0, 7);
      shape = (sel < 3) ? rspc_pkg::SHAPE_CIRCLE : (sel < 5) ? rspc_pkg::SHAPE_RECT :
              (sel < 7) ? rspc_pkg::SHAPE_LINE : rspc_pkg::SHAPE_NONE;
      cx = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom);
      cy = ($urandom_range(0, 3) == 0) ? 16'h7fff : 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         c = 16'($urandom);
         s = 16'($urandom);
      end else begin
         c = 16'($urandom_range(0, 32768) - 16384);
         s = 16'($urandom_range(0, 32768) - 16384);
      end
      ra = $urandom_range(0, 4096);
      rb = $urandom_range(0, 4096);
      eb = 16'(rb);
      if (shape == rspc_pkg::SHAPE_CIRCLE) begin
         ea = 40'(ra * ra);
         point_span = 2 * ra + 16;
      end else begin
         ea = 40'(ra);
         point_span = 2 * ((ra > rb) ? ra : rb) + 16;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         ea = 40'({$urandom, $urandom});
         point_span = 32768;
      end else if (sel == 1) begin
         ea = '0;
      end else if (sel == 2) begin
         eb = ($urandom_range(0, 1) == 0) ? 16'hffff : 16'($urandom);
         point_span = 32768;
      end
      set_figure(shape, cx, cy, c, s, ea, eb, 8'($urandom));
   endtask

   task automatic test_random_figures();
      int sent, count, cx, cy, x, y;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         random_figure();
         count = $urandom_range(40, 250);
         cx = int'(fig_centre_x);
         cy = int'(fig_centre_y);
         repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
               x = cx + int'($urandom_range(0, 2 * point_span)) - point_span;
               y = cy + int'($urandom_range(0, 2 * point_span)) - point_span;
            end else begin
               x = $urandom;
               y = $urandom;
            end
            send_point(COORD_W'(x), COORD_W'(y));
         end
         sent = sent + count;
         wait_for_results();
      end
   endtask

   initial begin
      reset_figure();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_extreme_figure();
      test_each_shape();
      test_random_figures();
      wait_for_results();
      if (cover_expect_q.size() != 0) begin
         mismatch_count = mismatch_count + 1;
         $display("missing transactions: %0d", cover_expect_q.size());
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/rspc_pkg.sv
rtl/rotated_shape_point_coverage_top.sv
tb/sv/rotated_shape_point_coverage_top_tb.sv
